>>> rtl/rbf_network_classify_unit_assert.svh
// ----------------------------------------------------------------------------
// RBF classifier assertion macros
// Shorthand for the concurrent checks of the classifier top level.
// ----------------------------------------------------------------------------
`ifndef RBF_NETWORK_CLASSIFY_UNIT_ASSERT_SVH
`define RBF_NETWORK_CLASSIFY_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define RBFC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RBFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/rbfc_pkg.sv
// ----------------------------------------------------------------------------
// RBF classifier package
// Shared widths, codes, the exponential step table and interface types.
// ----------------------------------------------------------------------------
package rbfc_pkg;

  localparam int MAX_DIMS_DEF    = 1024;
  localparam int MAX_CENTERS_DEF = 64;
  localparam int MAX_CLASSES_DEF = 16;

  localparam int FC_W       = 11;
  localparam int VAL_W      = 16;
  localparam int ACC_W      = 44;
  localparam int ACT_W      = 17;
  localparam int SCORE_W    = 40;
  localparam int GAMMA_W    = 24;
  localparam int CLS_OUT_W  = 4;
  localparam int CLS_IDX_W  = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [1:0] REQ_CENTER  = 2'd0;
  localparam logic [1:0] REQ_WEIGHT  = 2'd1;
  localparam logic [1:0] REQ_FEATURE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_INPUT_DIMS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_CENTERS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_CLASSES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAMMA       = 2'd3;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  // exp(-2^(k-12)) in Q1.31, each entry the rounded square of the one below
  function automatic logic [31:0] exp_q31(input int k);
    logic [63:0] e;
    int i;
    e = 64'd2146959424;
    for (i = 0; i < k; i++) begin
      e = (e * e + (64'd1 << 30)) >> 31;
    end
    return e[31:0];
  endfunction

  localparam logic [31:0] EXP_TAB [16] = '{
    exp_q31(0),  exp_q31(1),  exp_q31(2),  exp_q31(3),
    exp_q31(4),  exp_q31(5),  exp_q31(6),  exp_q31(7),
    exp_q31(8),  exp_q31(9),  exp_q31(10), exp_q31(11),
    exp_q31(12), exp_q31(13), exp_q31(14), exp_q31(15)
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_ACT_RD,
    ST_ACT_GO,
    ST_ACT_RUN,
    ST_SCORE,
    ST_OUT
  } fsm_st_t;

  typedef enum logic [2:0] {
    A_IDLE,
    A_MUL_HI,
    A_MUL_LO,
    A_SUM,
    A_EXP,
    A_RND
  } act_st_t;

  typedef struct packed {
    logic go;
    logic clr;
  } dist_cmd_t;

  typedef struct packed {
    logic [CLS_IDX_W-1:0]      cls;
    logic signed [SCORE_W-1:0] score;
  } score_res_t;

endpackage

>>> rtl/rbfc_dist.sv
// ----------------------------------------------------------------------------
// RBF classifier distance unit
// Center store and distance accumulators; one read-modify-write per center.
// ----------------------------------------------------------------------------
module rbfc_dist #(
  parameter int MAX_DIMS    = rbfc_pkg::MAX_DIMS_DEF,
  parameter int MAX_CENTERS = rbfc_pkg::MAX_CENTERS_DEF,
  localparam int CIW   = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1,
  localparam int NCW   = $clog2(MAX_CENTERS + 1),
  localparam int CDEP  = MAX_CENTERS * MAX_DIMS,
  localparam int CAW   = (CDEP > 1) ? $clog2(CDEP) : 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rbfc_pkg::dist_cmd_t               cmd,
  input  logic signed [rbfc_pkg::VAL_W-1:0] feat,
  input  logic [rbfc_pkg::FC_W-1:0]         fc,
  input  logic [NCW-1:0]                    nc,
  input  logic                              cw_en,
  input  logic [5:0]                        cw_row,
  input  logic [9:0]                        cw_col,
  input  logic [rbfc_pkg::VAL_W-1:0]        cw_data,
  input  logic [CIW-1:0]                    rd_idx,
  output logic [rbfc_pkg::ACC_W-1:0]        rd_data,
  output logic                              done
);

  logic [rbfc_pkg::VAL_W-1:0] cmem [CDEP];
  logic [rbfc_pkg::ACC_W-1:0] amem [MAX_CENTERS];
  logic [MAX_CENTERS-1:0]     vld_r;

  logic                              run_r;
  logic [NCW-1:0]                    j_r;
  logic signed [rbfc_pkg::VAL_W-1:0] feat_r;
  logic [rbfc_pkg::FC_W-1:0]         fc_r;
  logic [NCW-1:0]                    nc_r;

  logic [31:0]    cr_lin, cw_lin;
  logic [CAW-1:0] cr_addr, cw_addr;
  logic [CIW-1:0] ar_idx;

  logic [rbfc_pkg::VAL_W-1:0] c_q;
  logic [rbfc_pkg::ACC_W-1:0] a_q;
  logic                       vld_q;

  logic           s1_v_r, s1_last_r;
  logic [CIW-1:0] s1_idx_r;
  logic           s2_v_r, s2_last_r;
  logic [CIW-1:0] s2_idx_r;
  logic [33:0]    sq_r;
  logic [rbfc_pkg::ACC_W-1:0] s2_acc_r;

  logic signed [16:0]         diff;
  logic signed [33:0]         sqs;
  logic [rbfc_pkg::ACC_W:0]   sum;
  logic [rbfc_pkg::ACC_W-1:0] sum_sat;

  assign cr_lin  = 32'(j_r) * 32'(MAX_DIMS) + 32'(fc_r);
  assign cw_lin  = 32'(cw_row) * 32'(MAX_DIMS) + 32'(cw_col);
  assign cr_addr = cr_lin[CAW-1:0];
  assign cw_addr = cw_lin[CAW-1:0];
  assign ar_idx  = run_r ? j_r[CIW-1:0] : rd_idx;

  assign diff    = {feat_r[15], feat_r} - {c_q[15], c_q};
  assign sqs     = diff * diff;
  assign sum     = {1'b0, s2_acc_r} + (rbfc_pkg::ACC_W + 1)'(sq_r);
  assign sum_sat = sum[rbfc_pkg::ACC_W] ? rbfc_pkg::ACC_MAX : sum[rbfc_pkg::ACC_W-1:0];
  assign rd_data = vld_q ? a_q : '0;

  always_ff @(posedge clk) begin
    if (cw_en) begin
      cmem[cw_addr] <= cw_data;
    end
    c_q <= cmem[cr_addr];
  end

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      amem[s2_idx_r] <= sum_sat;
    end
    a_q <= amem[ar_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r     <= 1'b0;
      j_r       <= '0;
      s1_v_r    <= 1'b0;
      s1_last_r <= 1'b0;
      s2_v_r    <= 1'b0;
      s2_last_r <= 1'b0;
      vld_r     <= '0;
      vld_q     <= 1'b0;
      done      <= 1'b0;
    end else begin
      if (cmd.go) begin
        run_r <= 1'b1;
        j_r   <= '0;
      end else if (run_r) begin
        j_r <= j_r + NCW'(1);
        if (j_r == nc_r - NCW'(1)) begin
          run_r <= 1'b0;
        end
      end
      s1_v_r    <= run_r;
      s1_last_r <= run_r && (j_r == nc_r - NCW'(1));
      s2_v_r    <= s1_v_r;
      s2_last_r <= s1_last_r;
      vld_q     <= vld_r[ar_idx];
      if (cmd.clr) begin
        vld_r <= '0;
      end else if (s2_v_r) begin
        vld_r[s2_idx_r] <= 1'b1;
      end
      done <= s2_v_r && s2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      feat_r <= feat;
      fc_r   <= fc;
      nc_r   <= nc;
    end
    s1_idx_r <= j_r[CIW-1:0];
    s2_idx_r <= s1_idx_r;
    sq_r     <= sqs;
    s2_acc_r <= vld_q ? a_q : '0;
  end

endmodule

>>> rtl/rbfc_act.sv
// ----------------------------------------------------------------------------
// RBF classifier activation unit
// Computes exp(-gamma*d2) bit by bit of the Q4.12 argument, one step a cycle.
// ----------------------------------------------------------------------------
module rbfc_act (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [rbfc_pkg::ACC_W-1:0]          d2,
  input  logic [rbfc_pkg::GAMMA_W-1:0]        gamma,
  output logic                                done,
  output logic [rbfc_pkg::ACT_W-1:0]          act
);

  rbfc_pkg::act_st_t st_r, st_nxt;

  logic [rbfc_pkg::ACC_W-1:0]   d2_r;
  logic [rbfc_pkg::GAMMA_W-1:0] g_r;
  logic [45:0] ph_r, pl_r;
  logic [15:0] x_r;
  logic        big_r;
  logic [31:0] p_r;
  logic [3:0]  k_r;

  logic [47:0] x_sum;
  logic [63:0] p_mul;
  logic [32:0] p_rnd;
  logic [32:0] a_rnd;

  assign x_sum = {ph_r, 2'b00} + 48'(pl_r >> 20);
  assign p_mul = 64'(p_r) * 64'(rbfc_pkg::EXP_TAB[k_r]) + (64'd1 << 30);
  assign p_rnd = p_mul[63:31];
  assign a_rnd = 33'(p_r) + 33'(1 << 14);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      rbfc_pkg::A_IDLE:   if (start) st_nxt = rbfc_pkg::A_MUL_HI;
      rbfc_pkg::A_MUL_HI: st_nxt = rbfc_pkg::A_MUL_LO;
      rbfc_pkg::A_MUL_LO: st_nxt = rbfc_pkg::A_SUM;
      rbfc_pkg::A_SUM:    st_nxt = rbfc_pkg::A_EXP;
      rbfc_pkg::A_EXP:    if (k_r == 4'd15) st_nxt = rbfc_pkg::A_RND;
      rbfc_pkg::A_RND:    st_nxt = rbfc_pkg::A_IDLE;
      default:            st_nxt = rbfc_pkg::A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= rbfc_pkg::A_IDLE;
      done <= 1'b0;
    end else begin
      st_r <= st_nxt;
      done <= (st_r == rbfc_pkg::A_RND);
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      rbfc_pkg::A_IDLE: begin
        d2_r <= d2;
        g_r  <= gamma;
      end
      rbfc_pkg::A_MUL_HI: ph_r <= 46'(g_r) * 46'(d2_r[43:22]);
      rbfc_pkg::A_MUL_LO: pl_r <= 46'(g_r) * 46'(d2_r[21:0]);
      rbfc_pkg::A_SUM: begin
        x_r   <= x_sum[15:0];
        big_r <= (x_sum[47:16] != '0);
        p_r   <= 32'h8000_0000;
        k_r   <= '0;
      end
      rbfc_pkg::A_EXP: begin
        if (x_r[k_r]) begin
          p_r <= p_rnd[31:0];
        end
        k_r <= k_r + 4'd1;
      end
      rbfc_pkg::A_RND: act <= big_r ? '0 : a_rnd[31:15];
      default: ;
    endcase
  end

endmodule

>>> rtl/rbfc_score.sv
// ----------------------------------------------------------------------------
// RBF classifier score unit
// Weight and activation stores; per-class multiply-accumulate and argmax.
// ----------------------------------------------------------------------------
module rbfc_score #(
  parameter int MAX_CENTERS = rbfc_pkg::MAX_CENTERS_DEF,
  parameter int MAX_CLASSES = rbfc_pkg::MAX_CLASSES_DEF,
  localparam int CIW  = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1,
  localparam int NCW  = $clog2(MAX_CENTERS + 1),
  localparam int CLW  = $clog2(MAX_CLASSES),
  localparam int NLW  = $clog2(MAX_CLASSES + 1),
  localparam int WDEP = MAX_CLASSES * MAX_CENTERS,
  localparam int WAW  = $clog2(WDEP)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        w_we,
  input  logic [5:0]                  w_row,
  input  logic [9:0]                  w_col,
  input  logic [rbfc_pkg::VAL_W-1:0]  w_data,
  input  logic                        a_we,
  input  logic [CIW-1:0]              a_idx,
  input  logic [rbfc_pkg::ACT_W-1:0]  a_data,
  input  logic                        start,
  input  logic [NCW-1:0]              nc,
  input  logic [NLW-1:0]              ncl,
  output logic                        done,
  output rbfc_pkg::score_res_t        res
);

  logic [rbfc_pkg::VAL_W-1:0] wmem [WDEP];
  logic [rbfc_pkg::ACT_W-1:0] amem [MAX_CENTERS];

  logic           run_r;
  logic [NLW-1:0] c_r, ncl_r;
  logic [NCW-1:0] j_r, nc_r;
  logic           last_j, last_c;

  logic [31:0]    wr_lin, ww_lin;
  logic [WAW-1:0] wr_addr, ww_addr;

  logic signed [rbfc_pkg::VAL_W-1:0] w_q;
  logic [rbfc_pkg::ACT_W-1:0]        a_q;

  logic           s1_v_r, s1_first_r, s1_last_r, s1_fin_r;
  logic [CLW-1:0] s1_cls_r;
  logic           s2_v_r, s2_first_r, s2_last_r, s2_fin_r;
  logic [CLW-1:0] s2_cls_r;
  logic signed [33:0] prod_r;
  logic signed [rbfc_pkg::SCORE_W-1:0] sum_r, best_r;
  logic           cmp_v_r, cmp_fin_r;
  logic [CLW-1:0] cmp_cls_r, best_c_r;

  assign wr_lin  = 32'(c_r) * 32'(MAX_CENTERS) + 32'(j_r);
  assign ww_lin  = 32'(w_row) * 32'(MAX_CENTERS) + 32'(w_col);
  assign wr_addr = wr_lin[WAW-1:0];
  assign ww_addr = ww_lin[WAW-1:0];
  assign last_j  = (j_r == nc_r - NCW'(1));
  assign last_c  = (c_r == ncl_r - NLW'(1));

  assign res.cls   = rbfc_pkg::CLS_IDX_W'(best_c_r);
  assign res.score = best_r;

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[ww_addr] <= w_data;
    end
    w_q <= wmem[wr_addr];
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      amem[a_idx] <= a_data;
    end
    a_q <= amem[j_r[CIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      c_r     <= '0;
      j_r     <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      cmp_v_r <= 1'b0;
      done    <= 1'b0;
    end else begin
      if (start) begin
        run_r <= 1'b1;
        c_r   <= '0;
        j_r   <= '0;
      end else if (run_r) begin
        if (last_j) begin
          j_r <= '0;
          c_r <= c_r + NLW'(1);
          if (last_c) begin
            run_r <= 1'b0;
          end
        end else begin
          j_r <= j_r + NCW'(1);
        end
      end
      s1_v_r  <= run_r;
      s2_v_r  <= s1_v_r;
      cmp_v_r <= s2_v_r && s2_last_r;
      done    <= cmp_v_r && cmp_fin_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nc_r  <= nc;
      ncl_r <= ncl;
    end
    s1_first_r <= (j_r == '0);
    s1_last_r  <= last_j;
    s1_fin_r   <= last_j && last_c;
    s1_cls_r   <= c_r[CLW-1:0];
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_fin_r   <= s1_fin_r;
    s2_cls_r   <= s1_cls_r;
    prod_r     <= w_q * $signed({1'b0, a_q});
    if (s2_v_r) begin
      sum_r <= s2_first_r ? rbfc_pkg::SCORE_W'(prod_r)
                          : sum_r + rbfc_pkg::SCORE_W'(prod_r);
    end
    cmp_cls_r <= s2_cls_r;
    cmp_fin_r <= s2_fin_r;
    if (cmp_v_r && (cmp_cls_r == '0 || sum_r > best_r)) begin
      best_r   <= sum_r;
      best_c_r <= cmp_cls_r;
    end
  end

endmodule

>>> rtl/rbf_network_classify_unit.sv
// ----------------------------------------------------------------------------
// RBF network classifier
// Inference of a radial basis function classifier from stored centers/weights.
// ----------------------------------------------------------------------------
// Items arrive one at a time and each finishes before the next transfer is
// taken. A center or weight load goes straight into its store. For a
// feature element the distance unit walks the accumulator memory, one
// read-modify-write per center per cycle. The feature that closes a
// vector then runs the activation for each center in turn (the iterative
// exponential unit, one argument bit a cycle) and after that the weighted
// sums, which read the weight store one entry after another through its
// single read port; the result then waits in the output register while
// the next transfer is already taken. Accumulators clear at once through
// their valid bits; stores start undefined and need no sweep.
// ----------------------------------------------------------------------------
module rbf_network_classify_unit #(
  parameter int MAX_DIMS    = rbfc_pkg::MAX_DIMS_DEF,
  parameter int MAX_CENTERS = rbfc_pkg::MAX_CENTERS_DEF,
  parameter int MAX_CLASSES = rbfc_pkg::MAX_CLASSES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [1:0]                             in_req_type,
  input  logic [5:0]                             in_entry_row,
  input  logic [9:0]                             in_entry_col,
  input  logic signed [rbfc_pkg::VAL_W-1:0]      in_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [rbfc_pkg::CLS_OUT_W-1:0]         out_predicted_class,
  output logic signed [rbfc_pkg::SCORE_W-1:0]    out_best_score,
  input  logic                                   cfg_we,
  input  logic [rbfc_pkg::CFG_IDX_W-1:0]         cfg_idx,
  input  logic [rbfc_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  `include "rbf_network_classify_unit_assert.svh"

  localparam int CIW  = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
  localparam int NCW  = $clog2(MAX_CENTERS + 1);
  localparam int NLW  = $clog2(MAX_CLASSES + 1);
  localparam int DIMW = $clog2(MAX_DIMS + 1);

  // configuration registers
  logic [10:0]                        cfg_dims_r;
  logic [6:0]                         cfg_nc_r;
  logic [4:0]                         cfg_ncl_r;
  logic [rbfc_pkg::GAMMA_W-1:0]       cfg_gamma_r;

  logic [DIMW-1:0] dims_c;
  logic [NCW-1:0]  nc_c;
  logic [NLW-1:0]  ncl_c;

  rbfc_pkg::fsm_st_t st_r, st_nxt;

  logic [rbfc_pkg::FC_W-1:0] fc_r, fc_nxt;
  logic [NCW-1:0]            nc_r;
  logic [NLW-1:0]            ncl_r;
  logic                      fin_r;
  logic [NCW-1:0]            aj_r;

  logic in_xfer, is_feat, fin_now, in_dim;
  logic c_load, w_load;

  rbfc_pkg::dist_cmd_t  dcmd;
  rbfc_pkg::score_res_t sres;
  logic [rbfc_pkg::ACC_W-1:0] d2;
  logic [rbfc_pkg::ACT_W-1:0] act;
  logic dist_done, act_start, act_done, a_we, score_start, score_done, out_load;

  logic                                 out_valid_r;
  logic [rbfc_pkg::CLS_OUT_W-1:0]       out_cls_r;
  logic signed [rbfc_pkg::SCORE_W-1:0]  out_score_r;

  // Zero acts as one; values above the build limit saturate.
  always_comb begin
    if (cfg_dims_r == '0) begin
      dims_c = DIMW'(1);
    end else if (32'(cfg_dims_r) > 32'(MAX_DIMS)) begin
      dims_c = DIMW'(MAX_DIMS);
    end else begin
      dims_c = DIMW'(cfg_dims_r);
    end
    if (cfg_nc_r == '0) begin
      nc_c = NCW'(1);
    end else if (32'(cfg_nc_r) > 32'(MAX_CENTERS)) begin
      nc_c = NCW'(MAX_CENTERS);
    end else begin
      nc_c = NCW'(cfg_nc_r);
    end
    if (cfg_ncl_r == '0) begin
      ncl_c = NLW'(1);
    end else if (32'(cfg_ncl_r) > 32'(MAX_CLASSES)) begin
      ncl_c = NLW'(MAX_CLASSES);
    end else begin
      ncl_c = NLW'(cfg_ncl_r);
    end
  end

  assign in_ready = (st_r == rbfc_pkg::ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign is_feat  = in_xfer && (in_req_type == rbfc_pkg::REQ_FEATURE);
  assign fc_nxt   = fc_r + rbfc_pkg::FC_W'(1);
  assign fin_now  = (32'(fc_nxt) >= 32'(dims_c));
  // past the last stored dimension the feature only counts
  assign in_dim   = (32'(fc_r) < 32'(MAX_DIMS));

  // drop loads that fall outside the stores
  assign c_load = in_xfer && (in_req_type == rbfc_pkg::REQ_CENTER) &&
                  (32'(in_entry_row) < 32'(MAX_CENTERS)) &&
                  (32'(in_entry_col) < 32'(MAX_DIMS));
  assign w_load = in_xfer && (in_req_type == rbfc_pkg::REQ_WEIGHT) &&
                  (32'(in_entry_row) < 32'(MAX_CLASSES)) &&
                  (32'(in_entry_col) < 32'(MAX_CENTERS));

  // sequencer: distance pass, activation per center, scoring, result
  always_comb begin
    st_nxt      = st_r;
    dcmd.go     = 1'b0;
    dcmd.clr    = 1'b0;
    act_start   = 1'b0;
    a_we        = 1'b0;
    score_start = 1'b0;
    out_load    = 1'b0;
    unique case (st_r)
      rbfc_pkg::ST_IDLE: begin
        if (is_feat) begin
          if (in_dim) begin
            dcmd.go = 1'b1;
            st_nxt  = rbfc_pkg::ST_DIST;
          end else if (fin_now) begin
            st_nxt = rbfc_pkg::ST_ACT_RD;
          end
        end
      end
      rbfc_pkg::ST_DIST: begin
        if (dist_done) begin
          st_nxt = fin_r ? rbfc_pkg::ST_ACT_RD : rbfc_pkg::ST_IDLE;
        end
      end
      rbfc_pkg::ST_ACT_RD: st_nxt = rbfc_pkg::ST_ACT_GO;
      rbfc_pkg::ST_ACT_GO: begin
        act_start = 1'b1;
        st_nxt    = rbfc_pkg::ST_ACT_RUN;
      end
      rbfc_pkg::ST_ACT_RUN: begin
        if (act_done) begin
          a_we = 1'b1;
          if (aj_r == nc_r - NCW'(1)) begin
            score_start = 1'b1;
            st_nxt      = rbfc_pkg::ST_SCORE;
          end else begin
            st_nxt = rbfc_pkg::ST_ACT_RD;
          end
        end
      end
      rbfc_pkg::ST_SCORE: if (score_done) st_nxt = rbfc_pkg::ST_OUT;
      rbfc_pkg::ST_OUT: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          dcmd.clr = 1'b1;
          st_nxt   = rbfc_pkg::ST_IDLE;
        end
      end
      default: st_nxt = rbfc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= rbfc_pkg::ST_IDLE;
      cfg_dims_r  <= 11'd1024;
      cfg_nc_r    <= 7'd64;
      cfg_ncl_r   <= 5'd10;
      cfg_gamma_r <= 24'd65536;
      fc_r        <= '0;
      fin_r       <= 1'b0;
      aj_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          rbfc_pkg::REG_INPUT_DIMS:  cfg_dims_r  <= cfg_wdata[10:0];
          rbfc_pkg::REG_NUM_CENTERS: cfg_nc_r    <= cfg_wdata[6:0];
          rbfc_pkg::REG_NUM_CLASSES: cfg_ncl_r   <= cfg_wdata[4:0];
          rbfc_pkg::REG_GAMMA:       cfg_gamma_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (is_feat) begin
        fin_r <= fin_now;
        fc_r  <= fin_now ? '0 : fc_nxt;
      end
      // advance the activation index; restart it at each new vector
      if (st_r == rbfc_pkg::ST_IDLE) begin
        aj_r <= '0;
      end else if (act_done) begin
        aj_r <= aj_r + NCW'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_feat) begin
      nc_r  <= nc_c;
      ncl_r <= ncl_c;
    end
    if (out_load) begin
      out_cls_r   <= sres.cls[rbfc_pkg::CLS_OUT_W-1:0];
      out_score_r <= sres.score;
    end
  end

  rbfc_dist #(
    .MAX_DIMS    (MAX_DIMS),
    .MAX_CENTERS (MAX_CENTERS)
  ) u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (dcmd),
    .feat    (in_value),
    .fc      (fc_r),
    .nc      (nc_c),
    .cw_en   (c_load),
    .cw_row  (in_entry_row),
    .cw_col  (in_entry_col),
    .cw_data (in_value),
    .rd_idx  (aj_r[CIW-1:0]),
    .rd_data (d2),
    .done    (dist_done)
  );

  rbfc_act u_act (
    .clk   (clk),
    .rst_n (rst_n),
    .start (act_start),
    .d2    (d2),
    .gamma (cfg_gamma_r),
    .done  (act_done),
    .act   (act)
  );

  rbfc_score #(
    .MAX_CENTERS (MAX_CENTERS),
    .MAX_CLASSES (MAX_CLASSES)
  ) u_score (
    .clk    (clk),
    .rst_n  (rst_n),
    .w_we   (w_load),
    .w_row  (in_entry_row),
    .w_col  (in_entry_col),
    .w_data (in_value),
    .a_we   (a_we),
    .a_idx  (aj_r[CIW-1:0]),
    .a_data (act),
    .start  (score_start),
    .nc     (nc_r),
    .ncl    (ncl_r),
    .done   (score_done),
    .res    (sres)
  );

  assign out_valid           = out_valid_r;
  assign out_predicted_class = out_cls_r;
  assign out_best_score      = out_score_r;

  `RBFC_ASSERT_SAME(a_dist_done_in_dist, dist_done, st_r == rbfc_pkg::ST_DIST, "distance done outside distance pass")
  `RBFC_ASSERT_SAME(a_act_done_in_run, act_done, st_r == rbfc_pkg::ST_ACT_RUN, "activation done while not waiting")
  `RBFC_ASSERT_SAME(a_score_done_in_score, score_done, st_r == rbfc_pkg::ST_SCORE, "score done outside scoring")
  `RBFC_ASSERT_NEXT(a_load_shows_result, out_load, out_valid, "loaded result not presented")

endmodule
